// ===== rtl/core/adsd_pkg.sv =====
`timescale 1ns / 1ps

package adsd_pkg;

    localparam logic [3:0] HDR_SAMPLE_LO = 4'd3;
    localparam logic [3:0] HDR_SAMPLE_HI = 4'd6;
    localparam logic [3:0] HDR_COUNT     = 4'd7;
    localparam logic [3:0] HDR_AVERAGE   = 4'd10;
    localparam logic [3:0] HDR_LAST_POS  = 4'd15;

    localparam logic [7:0] COUNT_EMPTY   = 8'd2;

    localparam logic [7:0] MODE_MASK     = 8'h40;
    localparam logic [7:0] NIB_MASK      = 8'h0F;
    localparam logic [7:0] COARSE_MASK   = 8'h70;
    localparam logic [7:0] SMALL_MASK    = 8'h30;
    localparam logic [7:0] FINE_MASK     = 8'h3F;
    localparam logic [7:0] SIGN_MASK     = 8'h80;
    localparam logic [5:0] SHIFT_BIAS    = 6'd5;
    localparam logic [4:0] SMALL_SHIFT   = 5'd2;

    function automatic logic [4:0] floor_log2(input logic [31:0] v);
        logic [4:0] r;
        r = '0;
        for (int i = 1; i < 32; i++)
        begin
            if (v[i])
            begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] code_magnitude(input logic [7:0] code,
                                                   input logic [7:0] avg);
        logic [5:0]  q;
        logic [5:0]  sh;
        logic [4:0]  nib_sh;
        logic [31:0] m;
        q      = avg[7:2];
        sh     = (q < SHIFT_BIAS) ? 6'd0 : q - SHIFT_BIAS;
        nib_sh = {1'b0, code[3:0]} + 5'd1;
        if ((code & MODE_MASK) != 8'd0)
        begin
            if ((code & NIB_MASK) != 8'd0)
            begin
                m = {24'd0, code & COARSE_MASK} << nib_sh;
            end
            else
            begin
                m = {24'd0, code & SMALL_MASK} << SMALL_SHIFT;
            end
        end
        else if (sh[5])
        begin
            m = '0;
        end
        else
        begin
            m = {24'd0, code & FINE_MASK} << sh[4:0];
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/adaptive_delta_sample_decoder.sv =====
`timescale 1ns / 1ps
// Path: an accepted byte is held in the input register; the sample decoded from
// it is registered in the output register. Throughput: one byte per cycle unless
// a byte's sample waits for a full output register; the decode state updates as
// each byte leaves the input register, so the next byte already sees it.
// Reset (rst_n low, asynchronous): header phase, awaiting header byte 0,
// all decode state zero, no sample pending.

module adaptive_delta_sample_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               data_valid,
    output logic               data_ready,
    input  logic [7:0]         data_byte,
    input  logic               frame_start,
    output logic               sample_valid,
    input  logic               sample_ready,
    output logic signed [31:0] sample,
    output logic               last_sample
);
    import adsd_pkg::*;

    logic        byte_valid_reg;
    logic [7:0]  byte_reg;
    logic        start_reg;

    logic [3:0]  header_position_reg,  header_position_next;
    logic [31:0] running_sample_reg,   running_sample_next;
    logic [7:0]  remaining_codes_reg,  remaining_codes_next;
    logic [7:0]  count_byte_saved_reg, count_byte_saved_next;
    logic [7:0]  delta_average_reg,    delta_average_next;
    logic        in_code_phase_reg,    in_code_phase_next;

    logic        sample_valid_reg;
    logic [31:0] sample_reg;
    logic        last_sample_reg;

    logic [3:0]  pos_eff;
    logic        code_phase;
    logic [31:0] mag;
    logic [31:0] delta;
    logic [7:0]  avg_upd;
    logic [7:0]  codes_left;
    logic [1:0]  lane;
    logic        has_result;
    logic        res_last;
    logic        out_free;
    logic        stage_go;

    assign pos_eff    = start_reg ? 4'd0 : header_position_reg;
    assign code_phase = !start_reg && in_code_phase_reg;
    assign mag        = code_magnitude(byte_reg, delta_average_reg);
    assign delta      = ((byte_reg & SIGN_MASK) != 8'd0) ? (32'd0 - mag) : mag;
    assign avg_upd    = delta_average_reg - {2'b00, delta_average_reg[7:2]}
                        + {3'b000, floor_log2(mag)};
    assign codes_left = remaining_codes_reg - 8'd1;
    assign lane       = 2'(pos_eff - HDR_SAMPLE_LO);

    always_comb
    begin
        header_position_next  = pos_eff;
        running_sample_next   = running_sample_reg;
        remaining_codes_next  = remaining_codes_reg;
        count_byte_saved_next = count_byte_saved_reg;
        delta_average_next    = delta_average_reg;
        in_code_phase_next    = code_phase;
        has_result            = 1'b0;
        res_last              = 1'b0;
        if (code_phase)
        begin
            running_sample_next  = running_sample_reg + delta;
            delta_average_next   = avg_upd;
            remaining_codes_next = codes_left;
            has_result           = 1'b1;
            if (codes_left == 8'd0)
            begin
                res_last             = 1'b1;
                in_code_phase_next   = 1'b0;
                header_position_next = 4'd0;
            end
        end
        else if (pos_eff inside {[HDR_SAMPLE_LO:HDR_SAMPLE_HI]})
        begin
            running_sample_next[lane*8 +: 8] = byte_reg;
            header_position_next             = pos_eff + 4'd1;
        end
        else if (pos_eff == HDR_COUNT)
        begin
            count_byte_saved_next = byte_reg;
            header_position_next  = pos_eff + 4'd1;
        end
        else if (pos_eff inside {[HDR_AVERAGE:HDR_LAST_POS]})
        begin
            delta_average_next   = byte_reg;
            header_position_next = 4'd0;
            if (count_byte_saved_reg != COUNT_EMPTY)
            begin
                has_result = 1'b1;
                if (count_byte_saved_reg < COUNT_EMPTY)
                begin
                    res_last = 1'b1;
                end
                else
                begin
                    remaining_codes_next = count_byte_saved_reg - COUNT_EMPTY;
                    in_code_phase_next   = 1'b1;
                end
            end
        end
        else
        begin
            header_position_next = pos_eff + 4'd1;
        end
    end

    assign out_free   = !sample_valid_reg || sample_ready;
    assign stage_go   = byte_valid_reg && (!has_result || out_free);
    assign data_ready = !byte_valid_reg || stage_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (data_ready)
        begin
            byte_valid_reg <= data_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_valid && data_ready)
        begin
            byte_reg  <= data_byte;
            start_reg <= frame_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_position_reg  <= '0;
            running_sample_reg   <= '0;
            remaining_codes_reg  <= '0;
            count_byte_saved_reg <= '0;
            delta_average_reg    <= '0;
            in_code_phase_reg    <= 1'b0;
        end
        else if (stage_go)
        begin
            header_position_reg  <= header_position_next;
            running_sample_reg   <= running_sample_next;
            remaining_codes_reg  <= remaining_codes_next;
            count_byte_saved_reg <= count_byte_saved_next;
            delta_average_reg    <= delta_average_next;
            in_code_phase_reg    <= in_code_phase_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
        end
        else if (stage_go && has_result)
        begin
            sample_valid_reg <= 1'b1;
        end
        else if (sample_ready)
        begin
            sample_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_go && has_result)
        begin
            sample_reg      <= running_sample_next;
            last_sample_reg <= res_last;
        end
    end

    assign sample_valid = sample_valid_reg;
    assign sample       = signed'(sample_reg);
    assign last_sample  = last_sample_reg;

endmodule

// ===== rtl/core/adsd_checker.sv =====
`timescale 1ns / 1ps

module adsd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               data_valid,
    input logic               data_ready,
    input logic               sample_valid,
    input logic               sample_ready,
    input logic signed [31:0] sample,
    input logic               last_sample
);

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !sample_valid)
        else $error("sample_valid high after reset");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_valid |-> data_ready)
        else $error("data_ready low with no sample pending");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_ready |=> sample_valid)
        else $error("sample_valid dropped before transaction");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_ready |=> $stable(sample) && $stable(last_sample))
        else $error("sample payload changed while stalled");

endmodule

bind adaptive_delta_sample_decoder adsd_checker u_adsd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .data_valid   (data_valid),
    .data_ready   (data_ready),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .last_sample  (last_sample)
);
